[sv/averaged_pi_speed_controller_defines.svh]
// Assertion macros for the averaged PI speed controller.
// Included by the top level; no other dependencies.
`ifndef AVERAGED_PI_SPEED_CONTROLLER_DEFINES_SVH
`define AVERAGED_PI_SPEED_CONTROLLER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define APSC_ASSERT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("apsc assertion failed");
// Next-cycle implication, checked outside reset.
`define APSC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("apsc assertion failed");
`else
`define APSC_ASSERT(name, clk, rst_n, ante, cons)
`define APSC_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

[sv/apsc_pkg.sv]
// Shared constants for the averaged PI speed controller.
// No dependencies.
package apsc_pkg;

  localparam int unsigned RING_DEPTH = 4;
  localparam int unsigned RING_IDX_W = $clog2(RING_DEPTH);
  localparam int unsigned RING_CNT_W = $clog2(RING_DEPTH + 1);

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned SHIFT_W  = 4;
  localparam int unsigned DUTY_W   = 10;
  localparam int unsigned INTEG_W  = 16;

  localparam logic [DUTY_W-1:0]   DUTY_MAX       = 10'd1023;
  localparam logic [SAMPLE_W-1:0] RESTART_SAMPLE = 16'd30000;

  // Configuration register indexes.
  localparam int unsigned CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET_SPEED = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PROP_SHIFT   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_INTEG_SHIFT  = 2'd2;

  // Item operation codes.
  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_TICK = 1'b1
  } op_e;

endpackage

[sv/averaged_pi_speed_controller.sv]
// Averaged PI speed controller: one input register stage, one result register.
// Depends on apsc_pkg and averaged_pi_speed_controller_defines.svh.
//
// Items enter on the s_axis side: tuser selects push (0) or control tick (1),
// tdata carries the speed sample for a push. A push stores the sample in a
// four-slot ring and gives no result; a tick sums half of each slot, subtracts
// target_speed, updates the integral (saturating to -32768..1023) and returns
// one duty value (0..1023) on the m_axis side. Every item moves from the input
// register to the state or the result register, and one item is accepted each
// cycle while no tick waits; the integral and ring feed back through their own
// registers, so consecutive ticks run at full rate. A tick waits in the input
// register only while an earlier duty value is held on the result side. Write
// the configuration registers only while the block is idle.
`include "averaged_pi_speed_controller_defines.svh"

module averaged_pi_speed_controller (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [apsc_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [apsc_pkg::SAMPLE_W-1:0]     cfg_wdata_i,
  // Input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [15:0]                       s_axis_tdata,   // [15:0] sample
  input  logic                              s_axis_tuser,   // [0] operation
  // Result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [15:0]                       m_axis_tdata    // [9:0] duty, [15:10] zero
);

  localparam int unsigned SumW  = apsc_pkg::SAMPLE_W + 1;  // four halves
  localparam int unsigned ErrW  = SumW + 1;
  localparam int unsigned WideW = ErrW + 1;

  localparam logic signed [WideW-1:0] IntegHi = 19'sd1023;
  localparam logic signed [WideW-1:0] IntegLo = -19'sd32768;
  localparam logic signed [WideW-1:0] DutyHi  = 19'sd1023;

  localparam logic [apsc_pkg::RING_CNT_W-1:0] IdxMax =
    apsc_pkg::RING_CNT_W'(apsc_pkg::RING_DEPTH);
  localparam logic [apsc_pkg::RING_CNT_W-1:0] IdxOne = apsc_pkg::RING_CNT_W'(1);

  // Configuration registers
  logic [apsc_pkg::SAMPLE_W-1:0] target_q;
  logic [apsc_pkg::SHIFT_W-1:0]  prop_shift_q;
  logic [apsc_pkg::SHIFT_W-1:0]  integ_shift_q;

  // Input register
  logic                          in_valid_q;
  apsc_pkg::op_e                 in_op_q;
  logic [apsc_pkg::SAMPLE_W-1:0] in_sample_q;

  // Controller state
  logic [apsc_pkg::SAMPLE_W-1:0]   ring_q [apsc_pkg::RING_DEPTH];
  logic [apsc_pkg::RING_CNT_W-1:0] ring_idx_q;
  logic signed [apsc_pkg::INTEG_W-1:0] integ_q;

  // Result register
  logic                        out_valid_q;
  logic [apsc_pkg::DUTY_W-1:0] duty_q;

  logic out_free;
  logic go;
  logic go_tick;
  logic go_push;

  logic [SumW-1:0]                     sum_half;
  logic signed [ErrW-1:0]              err;
  logic signed [ErrW-1:0]              err_i;
  logic signed [ErrW-1:0]              err_p;
  logic signed [WideW-1:0]             integ_raw;
  logic signed [apsc_pkg::INTEG_W-1:0] integ_d;
  logic signed [WideW-1:0]             duty_raw;
  logic [apsc_pkg::DUTY_W-1:0]         duty_d;

  assign out_free      = !out_valid_q || m_axis_tready;
  // A push needs no result slot, so it proceeds even while a result waits.
  assign go            = in_valid_q && ((in_op_q == apsc_pkg::OP_PUSH) || out_free);
  assign go_tick       = go && (in_op_q == apsc_pkg::OP_TICK);
  assign go_push       = go && (in_op_q == apsc_pkg::OP_PUSH);
  assign s_axis_tready = !in_valid_q || go;

  always_comb begin
    sum_half = '0;
    for (int i = 0; i < apsc_pkg::RING_DEPTH; i++) begin
      sum_half = sum_half + {2'b00, ring_q[i][apsc_pkg::SAMPLE_W-1:1]};
    end
    err   = $signed({1'b0, sum_half}) - $signed({2'b00, target_q});
    err_i = err >>> integ_shift_q;
    err_p = err >>> prop_shift_q;

    integ_raw = {{(WideW-apsc_pkg::INTEG_W){integ_q[apsc_pkg::INTEG_W-1]}}, integ_q}
              + {err_i[ErrW-1], err_i};
    priority if (integ_raw > IntegHi) begin
      integ_d = IntegHi[apsc_pkg::INTEG_W-1:0];
    end else if (integ_raw < IntegLo) begin
      integ_d = IntegLo[apsc_pkg::INTEG_W-1:0];
    end else begin
      integ_d = integ_raw[apsc_pkg::INTEG_W-1:0];
    end

    duty_raw = {err_p[ErrW-1], err_p}
             + {{(WideW-apsc_pkg::INTEG_W){integ_d[apsc_pkg::INTEG_W-1]}}, integ_d};
    priority if (duty_raw > DutyHi) begin
      duty_d = apsc_pkg::DUTY_MAX;
    end else if (duty_raw[WideW-1]) begin
      duty_d = '0;
    end else begin
      duty_d = duty_raw[apsc_pkg::DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q      <= '0;
      prop_shift_q  <= '0;
      integ_shift_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        apsc_pkg::REG_TARGET_SPEED: target_q      <= cfg_wdata_i;
        apsc_pkg::REG_PROP_SHIFT:   prop_shift_q  <= cfg_wdata_i[apsc_pkg::SHIFT_W-1:0];
        apsc_pkg::REG_INTEG_SHIFT:  integ_shift_q <= cfg_wdata_i[apsc_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q     <= apsc_pkg::op_e'(s_axis_tuser);
      in_sample_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < apsc_pkg::RING_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
      ring_idx_q <= '0;
      integ_q    <= '0;
    end else if (go_push) begin
      if (ring_idx_q < IdxMax) begin
        ring_q[ring_idx_q[apsc_pkg::RING_IDX_W-1:0]] <= in_sample_q;
        ring_idx_q <= ring_idx_q + IdxOne;
      end else begin
        // Wrap: restart at slot 0.
        ring_q[0]  <= in_sample_q;
        ring_idx_q <= IdxOne;
      end
    end else if (go_tick) begin
      integ_q <= integ_d;
      // Empty slot 0 gets a restart value after this tick's error is formed.
      if (ring_q[0] == '0) begin
        ring_q[0] <= apsc_pkg::RESTART_SAMPLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= go_tick;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_tick) begin
      duty_q <= duty_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(16-apsc_pkg::DUTY_W){1'b0}}, duty_q};

  `APSC_ASSERT(a_idx_range, clk_i, rst_ni, 1'b1, ring_idx_q <= IdxMax)
  `APSC_ASSERT(a_integ_cap, clk_i, rst_ni, 1'b1, integ_q <= $signed(16'sd1023))
  `APSC_ASSERT_NEXT(a_tick_result, clk_i, rst_ni, go_tick, out_valid_q)
  `APSC_ASSERT_NEXT(a_slot0_live, clk_i, rst_ni, go_tick, ring_q[0] != '0)

endmodule

[tb/sv/apsc_duty_checker.sv]
`timescale 1ns / 100ps
// Checker for the averaged PI speed controller: tracks config writes and accepted items,
// predicts each duty value and compares it with what the result channel delivers.
// Depends on apsc_pkg only.
module apsc_duty_checker
  import apsc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [SAMPLE_W-1:0]   cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,   // [15:0] sample
  input  logic                  s_axis_tuser,   // [0] operation
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [15:0]           m_axis_tdata,   // [9:0] duty, [15:10] zero
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    pushes_o,
  output int                    ticks_o,
  output int                    duties_checked_o,
  output int                    ring_wraps_o,
  output int                    integ_ceil_hits_o,
  output int                    integ_floor_hits_o
);

  localparam int INTEG_CEIL  = 1023;
  localparam int INTEG_FLOOR = -(2 ** (INTEG_W - 1));

  logic [SAMPLE_W-1:0] speed_ring [RING_DEPTH];
  int unsigned         next_slot;
  int                  integ_acc;
  logic [SAMPLE_W-1:0] target_q;
  logic [SHIFT_W-1:0]  prop_shift_q;
  logic [SHIFT_W-1:0]  integ_shift_q;
  logic [DUTY_W-1:0]   duty_expected [$];

  int fails, pushes, ticks, checked, wraps, ceil_hits, floor_hits;

  assign fail_count_o       = fails;
  assign pushes_o           = pushes;
  assign ticks_o            = ticks;
  assign duties_checked_o   = checked;
  assign ring_wraps_o       = wraps;
  assign integ_ceil_hits_o  = ceil_hits;
  assign integ_floor_hits_o = floor_hits;

  // Run one control tick on the tracked state and return the duty it yields.
  function automatic logic [DUTY_W-1:0] predict_duty();
    int speed_err;
    int integ_next;
    int duty_val;
    speed_err = 0;
    for (int k = 0; k < RING_DEPTH; k++) speed_err += int'(speed_ring[k] >> 1);
    speed_err -= int'(target_q);

    integ_next = integ_acc + (speed_err >>> integ_shift_q);
    if (integ_next > INTEG_CEIL) begin
      integ_next = INTEG_CEIL;
      ceil_hits++;
    end
    if (integ_next < INTEG_FLOOR) begin
      integ_next = INTEG_FLOOR;
      floor_hits++;
    end
    integ_acc = integ_next;

    // The present tick still sees the empty slot; refill it afterwards.
    if (speed_ring[0] == '0) speed_ring[0] = RESTART_SAMPLE;

    duty_val = (speed_err >>> prop_shift_q) + integ_next;
    if (duty_val > int'(DUTY_MAX)) duty_val = int'(DUTY_MAX);
    if (duty_val < 0) duty_val = 0;
    return duty_val[DUTY_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [DUTY_W-1:0] want;
    logic [15:0]       want_word;
    if (!rst_ni) begin
      for (int k = 0; k < RING_DEPTH; k++) speed_ring[k] = '0;
      next_slot     = 0;
      integ_acc     = 0;
      target_q      = '0;
      prop_shift_q  = '0;
      integ_shift_q = '0;
      duty_expected.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_TARGET_SPEED: target_q      = cfg_wdata_i;
          REG_PROP_SHIFT:   prop_shift_q  = cfg_wdata_i[SHIFT_W-1:0];
          REG_INTEG_SHIFT:  integ_shift_q = cfg_wdata_i[SHIFT_W-1:0];
          default: ;
        endcase
      end

      if (s_axis_tvalid && s_axis_tready) begin
        if (op_e'(s_axis_tuser) == OP_TICK) begin
          ticks++;
          duty_expected.push_back(predict_duty());
        end else begin
          pushes++;
          if (next_slot < RING_DEPTH) begin
            speed_ring[next_slot] = s_axis_tdata[SAMPLE_W-1:0];
            next_slot++;
          end else begin
            // Ring full: restart at slot 0.
            speed_ring[0] = s_axis_tdata[SAMPLE_W-1:0];
            next_slot = 1;
            wraps++;
          end
        end
      end

      if (m_axis_tvalid && m_axis_tready) begin
        if (duty_expected.size() == 0) begin
          fails++;
          $display("%0t: unexpected result item, expected none, got duty %0d (tdata 0x%04h)",
                   $time, m_axis_tdata[DUTY_W-1:0], m_axis_tdata);
        end else begin
          want      = duty_expected.pop_front();
          want_word = {{(16 - DUTY_W){1'b0}}, want};
          checked++;
          if (m_axis_tdata !== want_word) begin
            fails++;
            $display("%0t: duty mismatch, expected %0d (0x%04h), got %0d (0x%04h)",
                     $time, want, want_word, m_axis_tdata[DUTY_W-1:0], m_axis_tdata);
          end
        end
      end

      pending_o <= duty_expected.size();
    end
  end

endmodule

[tb/sv/tb_averaged_pi_speed_controller.sv]
`timescale 1ns / 100ps
// Top of the averaged PI speed controller testbench: clock, reset, stimulus and verdict.
// Depends on apsc_pkg, averaged_pi_speed_controller and apsc_duty_checker.
module tb_averaged_pi_speed_controller;
  import apsc_pkg::*;

  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int CHUNK_ITEMS   = 25;
  localparam int CYCLE_LIMIT   = 200000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = REG_TARGET_SPEED;
  logic [SAMPLE_W-1:0]   cfg_wdata = '0;
  logic                  s_tvalid  = 1'b0;
  logic [15:0]           s_tdata   = '0;
  logic                  s_tuser   = OP_PUSH;
  logic                  m_tready  = 1'b0;
  logic                  s_tready;
  logic                  m_tvalid;
  logic [15:0]           m_tdata;

  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_seq  = 0;

  int fail_count, pending, pushes, ticks, checked, wraps, ceil_hits, floor_hits;

  averaged_pi_speed_controller dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  apsc_duty_checker checker_i (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_addr_i         (cfg_addr),
    .cfg_wdata_i        (cfg_wdata),
    .s_axis_tvalid      (s_tvalid),
    .s_axis_tready      (s_tready),
    .s_axis_tdata       (s_tdata),
    .s_axis_tuser       (s_tuser),
    .m_axis_tvalid      (m_tvalid),
    .m_axis_tready      (m_tready),
    .m_axis_tdata       (m_tdata),
    .fail_count_o       (fail_count),
    .pending_o          (pending),
    .pushes_o           (pushes),
    .ticks_o            (ticks),
    .duties_checked_o   (checked),
    .ring_wraps_o       (wraps),
    .integ_ceil_hits_o  (ceil_hits),
    .integ_floor_hits_o (floor_hits)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("%0t: timeout after %0d cycles, %0d duty values outstanding",
             $time, CYCLE_LIMIT, pending);
    $display("FAILURE");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off on each request.
  initial begin : duty_sink
    int hold_left;
    int hold_served;
    hold_left   = 0;
    hold_served = 0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_served) begin
        hold_served = hold_seq;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one item and hold it until accepted; maybe idle afterwards.
  task automatic send_item(input op_e op, input logic [15:0] smp);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= smp;
    do @(posedge clk); while (!s_tready);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Stop offering, wait for every duty value, then let trailing pushes settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] tgt, input logic [SHIFT_W-1:0] p_sh,
                            input logic [SHIFT_W-1:0] i_sh);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_TARGET_SPEED;
    cfg_wdata <= tgt;
    @(posedge clk);
    cfg_addr  <= REG_PROP_SHIFT;
    cfg_wdata <= SAMPLE_W'(p_sh);
    @(posedge clk);
    cfg_addr  <= REG_INTEG_SHIFT;
    cfg_wdata <= SAMPLE_W'(i_sh);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [SHIFT_W-1:0] pick_shift();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return SHIFT_W'($urandom_range(15));
    endcase
  endfunction

  task automatic random_config();
    logic [15:0] tgt;
    case ($urandom_range(4))
      0:       tgt = '0;
      1:       tgt = 16'hFFFF;
      default: tgt = 16'($urandom);
    endcase
    set_config(tgt, pick_shift(), pick_shift());
  endtask

  function automatic logic [15:0] pick_sample(input int unsigned span);
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(span));
    endcase
  endfunction

  // Mostly runs of pushes closed by a tick; now and then ticks back to back.
  task automatic random_chunk(input int n_items);
    int          sent;
    int          n_push;
    int unsigned span;
    sent = 0;
    span = $urandom_range(65535, 256);
    while (sent < n_items) begin
      n_push = ($urandom_range(7) == 0) ? 0 : $urandom_range(6, 1);
      repeat (n_push) send_item(OP_PUSH, pick_sample(span));
      send_item(OP_TICK, 16'($urandom));
      sent += n_push + 1;
    end
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty ring against the largest target drives the integral to its floor.
    set_config(16'hFFFF, '0, '0);
    send_item(OP_TICK, 16'h0000);
    send_item(OP_TICK, 16'hFFFF);
    repeat (4) send_item(OP_PUSH, 16'hFFFF);
    send_item(OP_TICK, 16'h0000);
    send_item(OP_PUSH, 16'h0000);
    send_item(OP_TICK, 16'h0000);
    drain();

    set_config(16'h0000, '1, '1);
    send_item(OP_TICK, 16'h0000);
    drain();

    // Positive error with no shift: integral climbs to its ceiling.
    set_config(16'h0000, '0, '0);
    repeat (3) send_item(OP_TICK, 16'h0000);
    repeat (4) send_item(OP_PUSH, 16'h0000);
    send_item(OP_TICK, 16'h0000);
    send_item(OP_PUSH, 16'h5555);
    send_item(OP_PUSH, 16'hAAAA);
    send_item(OP_TICK, 16'h0000);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 70; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 70; end
        default: begin idle_pct = 10; stall_pct <= 10; end
      endcase
      repeat (5) begin
        drain();
        random_config();
        random_chunk(CHUNK_ITEMS);
      end
      if (ph == 0) begin
        // Hold the result side off while ticks keep coming; the input must back up.
        hold_seq <= hold_seq + 1;
        repeat (30) send_item(OP_TICK, 16'($urandom));
      end
    end
    drain();

    $display("Checked %0d duty values from %0d pushes and %0d ticks (%0d ring wraps).",
             checked, pushes, ticks, wraps);
    $display("Integral clamped at its ceiling %0d times and at its floor %0d times.",
             ceil_hits, floor_hits);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
